// File: hdl/tbm_pkg.sv
`default_nettype none

package tbm_pkg;

    // field widths fixed by the item format
    localparam int STATE_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int START_W   = 16;
    localparam int END_POS_W = 16;

    localparam logic [END_POS_W-1:0] END_POS_MAX = 16'hFFFF;

    // every string starts its walk here, state zero means no transition
    localparam logic [STATE_W-1:0] START_STATE = 8'd1;
    localparam logic [STATE_W-1:0] DEAD_STATE  = 8'd0;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    typedef struct packed {
        logic                 matched;
        logic [STATE_W-1:0]   match_id;
        logic [END_POS_W-1:0] end_pos;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/table_dfa_byte_matcher.sv
`default_nettype none

// Table-driven automaton matcher. Write items (req_type 0) load one entry of the
// transition table, byte items (req_type 1) walk one string, starting in state 1,
// and the block gives one result item per string when the walk reaches the
// accept_state register, state 0, or the string's last byte. The table lives in
// one synchronous RAM of STATE_COUNT*256 entries; each item is accepted when
// in_valid and in_ready are both high, and a byte's lookup result feeds the next
// byte's read address directly, so a string streams at one byte per cycle while
// in_ready stays high; its result is registered into the result queue from
// stage one. A two-entry result queue, with room held for the byte in stage one,
// keeps bytes streaming while results are taken at once; while one result waits,
// input is taken only while stage one is empty, and two waiting results stop it.
// After reset the table is cleared one entry per cycle, up to the last entry;
// in_ready stays low meanwhile while accept_state writes are still taken.
module table_dfa_byte_matcher #(
    parameter int STATE_COUNT = 256,
    parameter int POS_BITS    = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tbm_pkg::STATE_W-1:0]     cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            req_type,
    input  wire logic [tbm_pkg::STATE_W-1:0]     from_state,
    input  wire logic [tbm_pkg::BYTE_W-1:0]      byte_value,
    input  wire logic [tbm_pkg::STATE_W-1:0]     to_state,
    input  wire logic [tbm_pkg::START_W-1:0]     start_pos,
    input  wire logic                            last_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 matched,
    output logic [tbm_pkg::STATE_W-1:0]          match_id,
    output logic [tbm_pkg::END_POS_W-1:0]        end_pos
);

    localparam int ROW_BITS  = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int DEPTH     = STATE_COUNT * 256;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_COUNT = 1 << tbm_pkg::STATE_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // state number to table row, folded at elaboration
    logic [ROW_BITS-1:0] row_lut [ROW_COUNT];
    for (genvar g = 0; g < ROW_COUNT; g++)
    begin : g_row
        assign row_lut[g] = ROW_BITS'(g % STATE_COUNT);
    end

    // registers
    logic                          clr_busy_reg;
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic [tbm_pkg::STATE_W-1:0]   accept_reg;
    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic [tbm_pkg::START_W-1:0]   s1_start_reg;
    logic                          started_reg, started_next;
    logic                          done_reg, done_next;
    logic [tbm_pkg::STATE_W-1:0]   cur_reg, cur_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    tbm_pkg::result_t              q_data_reg [2];
    logic                          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                    occ_reg;

    logic                          accept;
    logic                          pop;
    logic                          push;
    logic [1:0]                    used;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [tbm_pkg::STATE_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [tbm_pkg::STATE_W-1:0]   ram_rdata;
    logic [tbm_pkg::STATE_W-1:0]   addr_state;
    logic                          s1_done_in;
    logic [tbm_pkg::STATE_W-1:0]   s1_cur_in;
    logic [POS_BITS-1:0]           s1_pos_in;
    logic [POS_BITS-1:0]           start_clamp;
    logic [tbm_pkg::END_POS_W-1:0] end_pos_sat;
    logic                          hit_accept, hit_dead;
    tbm_pkg::result_t              s1_result;

    // handshake, room is reserved for any result still in flight
    assign pop      = out_valid && out_ready;
    assign used     = occ_reg + {1'b0, s1_valid_reg};
    assign in_ready = !clr_busy_reg && (pop ? (used != 2'd3) : (used < 2'd2));
    assign accept   = in_valid && in_ready;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // accept state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            accept_reg <= cfg_wr_data;
        end
    end

    // table port mux: clearing or write items
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = tbm_pkg::DEAD_STATE;
        end
        else
        begin
            ram_we    = accept && (req_type == tbm_pkg::REQ_WRITE);
            ram_waddr = {row_lut[from_state], byte_value};
            ram_wdata = to_state;
        end
    end

    // lookup address uses the state the stage-one byte leaves behind
    assign addr_state = started_next ? cur_next : tbm_pkg::START_STATE;
    assign ram_re     = accept && (req_type == tbm_pkg::REQ_BYTE);
    assign ram_raddr  = {row_lut[addr_state], byte_value};

    tbm_ram #(
        .WIDTH (tbm_pkg::STATE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // stage one holds the byte whose lookup is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ram_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_last_reg  <= last_byte;
            s1_start_reg <= start_pos;
        end
    end

    // start position clamp and result position saturation
    if (POS_BITS >= tbm_pkg::START_W)
    begin : g_wide_start
        assign start_clamp = POS_BITS'(s1_start_reg);
    end
    else
    begin : g_narrow_start
        assign start_clamp = (|s1_start_reg[tbm_pkg::START_W-1:POS_BITS]) ?
                             '1 : s1_start_reg[POS_BITS-1:0];
    end

    if (POS_BITS <= tbm_pkg::END_POS_W)
    begin : g_narrow_end
        assign end_pos_sat = tbm_pkg::END_POS_W'(s1_pos_in);
    end
    else
    begin : g_wide_end
        assign end_pos_sat = (|s1_pos_in[POS_BITS-1:tbm_pkg::END_POS_W]) ?
                             tbm_pkg::END_POS_MAX : s1_pos_in[tbm_pkg::END_POS_W-1:0];
    end

    // walk step: fold in string start, then take the table result
    always_comb
    begin
        if (started_reg)
        begin
            s1_done_in = done_reg;
            s1_cur_in  = cur_reg;
            s1_pos_in  = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
        end
        else
        begin
            s1_done_in = 1'b0;
            s1_cur_in  = tbm_pkg::START_STATE;
            s1_pos_in  = start_clamp;
        end

        hit_accept = (ram_rdata == accept_reg);
        hit_dead   = (ram_rdata == tbm_pkg::DEAD_STATE);
        push       = s1_valid_reg && !s1_done_in && (hit_accept || hit_dead || s1_last_reg);

        s1_result.end_pos = end_pos_sat;
        priority if (hit_accept)
        begin
            s1_result.matched  = 1'b1;
            s1_result.match_id = s1_cur_in;
        end
        else if (hit_dead)
        begin
            s1_result.matched  = 1'b0;
            s1_result.match_id = tbm_pkg::DEAD_STATE;
        end
        else
        begin
            s1_result.matched  = 1'b1;
            s1_result.match_id = ram_rdata;
        end

        started_next = started_reg;
        done_next    = done_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        if (s1_valid_reg)
        begin
            pos_next = s1_pos_in;
            cur_next = s1_done_in ? s1_cur_in : ram_rdata;
            if (s1_last_reg)
            begin
                started_next = 1'b0;
                done_next    = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                done_next    = s1_done_in || push;
            end
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            cur_reg     <= tbm_pkg::START_STATE;
            pos_reg     <= '0;
        end
        else
        begin
            started_reg <= started_next;
            done_reg    <= done_next;
            cur_reg     <= cur_next;
            pos_reg     <= pos_next;
        end
    end

    // two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            occ_reg <= occ_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= s1_result;
        end
    end

    assign out_valid = (occ_reg != 2'd0);
    assign matched   = q_data_reg[rd_ptr_reg].matched;
    assign match_id  = q_data_reg[rd_ptr_reg].match_id;
    assign end_pos   = q_data_reg[rd_ptr_reg].end_pos;

endmodule

`default_nettype wire

// File: hdl/tbm_ram.sv
`default_nettype none

module tbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/tbm_checker.sv
`default_nettype none

module tbm_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            req_type,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic                            matched,
    input wire logic [tbm_pkg::STATE_W-1:0]     match_id,
    input wire logic [tbm_pkg::END_POS_W-1:0]   end_pos
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({matched, match_id, end_pos}))
        else $error("result item changed while stalled");

    // a miss never reports a state
    a_miss_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> match_id == tbm_pkg::DEAD_STATE)
        else $error("miss result carries a nonzero match_id");

    // the table is being cleared right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("item accepted during table clearing");

    // a fresh result follows an accepted byte item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && req_type == tbm_pkg::REQ_BYTE, 2))
        else $error("result item without a byte item behind it");

endmodule

bind table_dfa_byte_matcher tbm_checker u_tbm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .matched     (matched),
    .match_id    (match_id),
    .end_pos     (end_pos)
);

`default_nettype wire
